@@ hdl/digit_settable_countdown_timer_unit_assert.svh @@
// Assertion helpers for the countdown timer.
`ifndef DIGIT_SETTABLE_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define DIGIT_SETTABLE_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must hold at every edge outside reset
`define DSCT_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// ante implies cons in the same cycle
`define DSCT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define DSCT_ASSERT(lbl, clk, rst, cond)
`define DSCT_ASSERT_IMP(lbl, clk, rst, ante, cons)

`endif

`endif

@@ hdl/dsct_pkg.sv @@
package dsct_pkg;

  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] COUNT_MAX    = 17'd86399;
  localparam logic [CNT_W:0]   DAY_SEC      = 18'd86400;
  localparam logic [CNT_W-1:0] PRESET_RESET = 17'd30;
  localparam logic [CNT_W-1:0] HOUR_SEC     = 17'd3600;
  localparam logic [11:0]      MIN_SEC      = 12'd60;

  // floor(x * RECIP >> SHIFT) == floor(x / divisor) over the used range
  localparam logic [15:0] HOUR_RECIP = 16'd37283;  // 2^27 / 3600, rounded up
  localparam logic [12:0] MIN_RECIP  = 13'd4370;   // 2^18 / 60, rounded up

  typedef enum logic [2:0] {
    EV_TICK  = 3'd0,
    EV_DEC   = 3'd1,
    EV_INC   = 3'd2,
    EV_HOLD  = 3'd3,
    EV_START = 3'd4,
    EV_STOP  = 3'd5,
    EV_CLEAR = 3'd6,
    EV_NOP   = 3'd7
  } event_t;

  // cursor columns that select a digit
  localparam logic [3:0] CUR_10H = 4'd7;
  localparam logic [3:0] CUR_1H  = 4'd8;
  localparam logic [3:0] CUR_10M = 4'd10;
  localparam logic [3:0] CUR_1M  = 4'd11;
  localparam logic [3:0] CUR_10S = 4'd13;
  localparam logic [3:0] CUR_1S  = 4'd14;

  // count word handed from the state update to the h:m:s converter
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             buzzer;
    logic             running;
  } cnt_word_t;

  function automatic logic [CNT_W-1:0] digit_weight(input logic [3:0] pos);
    logic [CNT_W-1:0] w;
    case (pos)
      CUR_10H: w = 17'd36000;
      CUR_1H:  w = 17'd3600;
      CUR_10M: w = 17'd600;
      CUR_1M:  w = 17'd60;
      CUR_10S: w = 17'd10;
      CUR_1S:  w = 17'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

@@ hdl/dsct_core.sv @@
// Input register and timer state update.
module dsct_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [3:0]         in_pos,
  input  logic               in_page,
  output logic               word_valid,
  input  logic               word_ready,
  output dsct_pkg::cnt_word_t word
);
  import dsct_pkg::*;

  logic             v0;
  event_t           mode0;
  logic [3:0]       pos0;
  logic             page0;

  logic [CNT_W-1:0] preset;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] set_val;
  logic             run_flag;
  logic             alarm;

  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] set_val_next;
  logic             run_flag_next;
  logic             alarm_next;

  logic [CNT_W-1:0] w;
  logic [CNT_W:0]   inc_sum;
  logic             may_set;
  logic             fire;

  assign in_ready   = !v0 || word_ready;
  assign fire       = v0 && word_ready;
  assign word_valid = v0;

  assign w       = digit_weight(pos0);
  assign inc_sum = {1'b0, set_val} + {1'b0, w};
  assign may_set = page0 && !run_flag;

  always_comb begin
    count_next    = count;
    set_val_next  = set_val;
    run_flag_next = run_flag;
    alarm_next    = alarm;
    unique case (mode0)
      EV_TICK: begin
        if (run_flag && count != '0) count_next = count - 17'd1;
      end
      EV_DEC: begin
        if (may_set && w != '0 && set_val >= w) set_val_next = set_val - w;
      end
      EV_INC: begin
        if (may_set && w != '0 && inc_sum < DAY_SEC) set_val_next = inc_sum[CNT_W-1:0];
      end
      EV_HOLD: begin
        if (may_set) set_val_next = (preset > COUNT_MAX) ? COUNT_MAX : preset;
      end
      EV_START: run_flag_next = 1'b1;
      EV_STOP:  run_flag_next = 1'b0;
      EV_CLEAR: alarm_next = 1'b0;
      EV_NOP:   ;
      default:  ;
    endcase
    if (!run_flag_next) count_next = set_val_next;
    // expiry
    if (run_flag_next && count_next == '0) begin
      alarm_next    = 1'b1;
      run_flag_next = 1'b0;
      count_next    = set_val_next;
    end
  end

  assign word.count   = count_next;
  assign word.buzzer  = alarm_next;
  assign word.running = run_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      preset   <= PRESET_RESET;
      count    <= PRESET_RESET;
      set_val  <= PRESET_RESET;
      run_flag <= 1'b0;
      alarm    <= 1'b0;
    end else begin
      if (in_ready) v0 <= in_valid;
      if (cfg_we) preset <= cfg_wdata;
      if (fire) begin
        count    <= count_next;
        set_val  <= set_val_next;
        run_flag <= run_flag_next;
        alarm    <= alarm_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mode0 <= event_t'(in_mode);
      pos0  <= in_pos;
      page0 <= in_page;
    end
  end

endmodule

@@ hdl/dsct_hms.sv @@
// Seconds count to h:m:s, reciprocal multiplies, one product per stage.
module dsct_hms (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsct_pkg::cnt_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          hours,
  output logic [5:0]          minutes,
  output logic [5:0]          seconds,
  output logic                buzzer,
  output logic                running
);
  import dsct_pkg::*;

  logic va, vb, vc, vd;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  cnt_word_t        wa, wb;
  logic [4:0]       hb, hc, hd;
  logic [1:0]       fc, fd;        // {buzzer, running}
  logic [11:0]      rc, rd;
  logic [5:0]       md;

  logic [32:0]      prod_h;
  logic [CNT_W-1:0] rem_full;
  logic [24:0]      prod_m;
  logic [11:0]      sec_full;

  assign rdy_o    = !out_valid || out_ready;
  assign rdy_d    = !vd || rdy_o;
  assign rdy_c    = !vc || rdy_d;
  assign rdy_b    = !vb || rdy_c;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  assign prod_h   = 33'(wa.count) * 33'(HOUR_RECIP);
  assign rem_full = wb.count - (17'(hb) * HOUR_SEC);
  assign prod_m   = 25'(rc) * 25'(MIN_RECIP);
  assign sec_full = rd - (12'(md) * MIN_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) vb <= va;
      if (rdy_c) vc <= vb;
      if (rdy_d) vd <= vc;
      if (rdy_o) out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) wa <= in_word;
    if (rdy_b && va) begin
      wb <= wa;
      hb <= prod_h[31:27];
    end
    if (rdy_c && vb) begin
      hc <= hb;
      rc <= rem_full[11:0];
      fc <= {wb.buzzer, wb.running};
    end
    if (rdy_d && vc) begin
      hd <= hc;
      rd <= rc;
      md <= prod_m[23:18];
      fd <= fc;
    end
    if (rdy_o && vd) begin
      hours   <= hd;
      minutes <= md;
      seconds <= sec_full[5:0];
      buzzer  <= fd[1];
      running <= fd[0];
    end
  end

endmodule

@@ hdl/digit_settable_countdown_timer_unit.sv @@
// Countdown timer, whole seconds, with a set mode and a run mode. Each input
// word is one event (tick, digit step, hold, start, stop, clear alarm) and
// gives exactly one output word with the remaining count as h:m:s, the
// buzzer flag and the running flag, reflecting the state after the event.
// An event is taken every cycle while the output side keeps up. An accepted
// event sits in the input register while the state update runs, then a
// capture register and four converter stages follow: hours by reciprocal
// multiply, hour remainder, minutes by reciprocal multiply, seconds.
// Latency is set by the input register and the converter pipeline; throughput
// is one word per cycle while the output side keeps up, as the state update is combinational.
// The user must write the preset register with cfg_we/cfg_wdata while no
// event is in flight; the block itself does not enforce this. It resets to 30
// seconds, and a hold loads it saturated to 23:59:59.
`include "digit_settable_countdown_timer_unit_assert.svh"

module digit_settable_countdown_timer_unit (
  input  logic        clk,
  input  logic        rst,
  // preset register write
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,     // preset_seconds
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [3:0] cursor_pos, [4] on_timer_page, [7:5] zero
  input  logic [2:0]  s_tuser,       // [2:0] mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                     // [17] buzzer, [18] running, [23:19] zero
);
  import dsct_pkg::*;

  cnt_word_t   word;
  logic        word_valid;
  logic        word_ready;

  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic        buzzer;
  logic        running;

  dsct_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_mode    (s_tuser),
    .in_pos     (s_tdata[3:0]),
    .in_page    (s_tdata[4]),
    .word_valid (word_valid),
    .word_ready (word_ready),
    .word       (word)
  );

  dsct_hms u_hms (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (word_valid),
    .in_ready  (word_ready),
    .in_word   (word),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .hours     (hours),
    .minutes   (minutes),
    .seconds   (seconds),
    .buzzer    (buzzer),
    .running   (running)
  );

  assign m_tdata = {5'd0, running, buzzer, seconds, minutes, hours};

  // count never leaves one day
  `DSCT_ASSERT_IMP(a_count_range, clk, rst, word_valid, word.count <= COUNT_MAX)
  // reciprocal divides stay in range
  `DSCT_ASSERT_IMP(a_hms_range, clk, rst, m_tvalid,
    (hours <= 5'd23) && (minutes <= 6'd59) && (seconds <= 6'd59))
  // input stalls only when the whole pipe is full behind a held result
  `DSCT_ASSERT_IMP(a_stall_full, clk, rst, !s_tready, m_tvalid && !m_tready)

endmodule

@@ test/tb_top.sv @@
module tb_top;
  import dsct_pkg::*;

  // Quiet limit: cycles with no word moved on either side. Allows the long
  // output hold-off plus the slowest random gaps many times over.
  localparam int WATCHDOG_LIMIT = 4000;
  // Output hold-off length for the back-pressure test.
  localparam int HOLD_CYCLES    = 200;
  // Extra cycles after the last result; pipeline depth is six.
  localparam int SETTLE_CYCLES  = 12;
  localparam int RANDOM_PER_PHASE = 400;

  // one result word, fields as the block reports them
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       buzzer;
    logic       running;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;       // [3:0] cursor_pos, [4] on_timer_page, [7:5] zero
  logic [2:0]  s_tuser = EV_NOP;   // [2:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;            // [4:0] hours, [10:5] minutes, [16:11] seconds,
                                   // [17] buzzer, [18] running, [23:19] zero

  digit_settable_countdown_timer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle / stall rates in percent, set per phase by the test tasks
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int mismatches     = 0;
  // hold-off requests: bumped by a test, taken up by the receiver process
  int hold_reqs      = 0;

  // timer state as predicted
  logic [CNT_W-1:0] preset_val;
  logic [CNT_W-1:0] count_left;
  logic [CNT_W-1:0] set_val;
  logic             run_on;
  logic             alarm_on;

  timer_result_t pending_results[$];

  // Seconds that one step moves at a cursor column; 0 = column holds no digit.
  function automatic logic [CNT_W-1:0] place_value(input logic [3:0] cur);
    case (cur)
      CUR_10H: return 17'd36000;
      CUR_1H:  return 17'd3600;
      CUR_10M: return 17'd600;
      CUR_1M:  return 17'd60;
      CUR_10S: return 17'd10;
      CUR_1S:  return 17'd1;
      default: return '0;
    endcase
  endfunction

  // Apply one event to the predicted state and return the word it reports.
  function automatic timer_result_t advance_timer(input event_t ev, input logic [3:0] cur,
                                                  input logic pg);
    timer_result_t    r;
    logic             editable;
    logic [CNT_W-1:0] step;
    editable = pg && !run_on;
    step     = place_value(cur);
    case (ev)
      EV_TICK:  if (run_on && count_left != 0) count_left = count_left - 1'b1;
      EV_DEC:   if (editable && step != 0 && set_val >= step) set_val = set_val - step;
      EV_INC:   if (editable && step != 0 && ({1'b0, set_val} + step) < DAY_SEC)
                  set_val = set_val + step;
      EV_HOLD:  if (editable) set_val = (preset_val > COUNT_MAX) ? COUNT_MAX : preset_val;
      EV_START: run_on = 1'b1;
      EV_STOP:  run_on = 1'b0;
      EV_CLEAR: alarm_on = 1'b0;
      default:  ;
    endcase
    // set mode: count tracks the set value
    if (!run_on) count_left = set_val;
    // expiry: running count at zero raises the alarm and reloads
    if (run_on && count_left == 0) begin
      alarm_on   = 1'b1;
      run_on     = 1'b0;
      count_left = set_val;
    end
    if (count_left > COUNT_MAX) count_left = COUNT_MAX;
    r.hours   = 5'(count_left / 3600);
    r.minutes = 6'((count_left % 3600) / 60);
    r.seconds = 6'(count_left % 60);
    r.buzzer  = alarm_on;
    r.running = run_on;
    return r;
  endfunction

  // Scoreboard: check the output word first, then record the prediction for
  // the input word taken at the same edge (the output is registered behind the input).
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    if (rst) begin
      preset_val = PRESET_RESET;
      count_left = PRESET_RESET;
      set_val    = PRESET_RESET;
      run_on     = 1'b0;
      alarm_on   = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[4:0], m_tdata[10:5], m_tdata[16:11], m_tdata[17], m_tdata[18]};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: h=%0d m=%0d s=%0d buz=%0b run=%0b",
                     got.hours, got.minutes, got.seconds, got.buzzer, got.running);
        end else begin
          want = pending_results.pop_front();
          if (got.hours !== want.hours || got.minutes !== want.minutes ||
              got.seconds !== want.seconds || got.buzzer !== want.buzzer ||
              got.running !== want.running) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp h=%0d m=%0d s=%0d buz=%0b run=%0b, got h=%0d m=%0d s=%0d buz=%0b run=%0b",
                       want.hours, want.minutes, want.seconds, want.buzzer, want.running,
                       got.hours, got.minutes, got.seconds, got.buzzer, got.running);
          end
        end
      end
      if (cfg_we) preset_val = cfg_wdata;
      if (s_tvalid && s_tready)
        pending_results.push_back(advance_timer(event_t'(s_tuser), s_tdata[3:0], s_tdata[4]));
    end
  end

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(negedge clk) begin
    int hold_taken;
    int hold_left;
    if (hold_reqs != hold_taken) begin
      hold_taken = hold_reqs;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog: too long with no word moving on either side.
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one event word and wait until taken. Entered and left at a falling
  // edge; tvalid stays high so back-to-back words need no reassertion.
  task automatic send_event(input event_t ev, input logic [3:0] cur, input logic pg);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ev;
    s_tdata  <= {3'b000, pg, cur};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop tvalid and wait for every predicted word, then let the pipe settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_preset(input logic [16:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [3:0] pick_cursor();
    case ($urandom_range(9))
      0, 1, 2: return CUR_1S;
      3, 4:    return CUR_10S;
      5:       return CUR_1M;
      6:       return CUR_10M;
      7:       return CUR_1H;
      8:       return CUR_10H;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  task automatic send_noise();
    send_event(event_t'(3'($urandom_range(7))), 4'($urandom_range(15)),
               1'($urandom_range(1)));
  endtask

  // Set a value, start, tick toward zero with some noise mixed in.
  // Small presets plus few steps keep many runs short enough to expire.
  task automatic countdown_sequence();
    int steps;
    int ticks;
    if ($urandom_range(1)) send_event(EV_HOLD, 4'($urandom_range(15)), 1'b1);
    steps = $urandom_range(4);
    repeat (steps)
      send_event($urandom_range(1) ? EV_INC : EV_DEC, pick_cursor(), $urandom_range(9) != 0);
    send_event(EV_START, 4'($urandom_range(15)), 1'($urandom_range(1)));
    ticks = $urandom_range(60);
    repeat (ticks) begin
      if ($urandom_range(19) == 0) send_noise();
      else send_event(EV_TICK, 4'($urandom_range(15)), 1'($urandom_range(1)));
    end
    if ($urandom_range(2) == 0) send_event(EV_STOP, 4'($urandom_range(15)), 1'($urandom_range(1)));
    if ($urandom_range(2) != 0) send_event(EV_CLEAR, 4'($urandom_range(15)), 1'($urandom_range(1)));
  endtask

  // Every event kind, every digit, refused steps, off-page and running
  // steps, instant expiry from zero, tick-driven expiry.
  task automatic test_directed_events();
    send_event(EV_NOP,   4'd15,   1'b0);
    send_event(EV_TICK,  4'd0,    1'b1);   // tick in set mode does nothing
    send_event(EV_INC,   CUR_10H, 1'b1);
    send_event(EV_INC,   CUR_10H, 1'b1);
    send_event(EV_INC,   CUR_1H,  1'b1);
    send_event(EV_INC,   CUR_10M, 1'b1);
    send_event(EV_INC,   CUR_1M,  1'b1);
    send_event(EV_INC,   CUR_10S, 1'b1);
    send_event(EV_INC,   CUR_1S,  1'b1);
    send_event(EV_INC,   4'd12,   1'b1);   // column without a digit
    send_event(EV_INC,   CUR_1S,  1'b0);   // off the timer page
    send_event(EV_DEC,   CUR_10H, 1'b1);
    send_event(EV_HOLD,  4'd0,    1'b1);   // back to reset preset
    send_event(EV_DEC,   CUR_10S, 1'b1);
    send_event(EV_DEC,   CUR_10S, 1'b1);
    send_event(EV_DEC,   CUR_10S, 1'b1);
    send_event(EV_DEC,   CUR_1S,  1'b1);   // below zero, refused
    send_event(EV_START, 4'd0,    1'b0);   // zero set value: expires at once
    send_event(EV_CLEAR, 4'd0,    1'b0);
    send_event(EV_INC,   CUR_1S,  1'b1);
    send_event(EV_INC,   CUR_1S,  1'b1);
    send_event(EV_START, 4'd0,    1'b1);
    send_event(EV_INC,   CUR_1S,  1'b1);   // ignored while running
    send_event(EV_START, 4'd0,    1'b1);   // already running
    send_event(EV_TICK,  4'd0,    1'b0);
    send_event(EV_TICK,  4'd15,   1'b1);   // reaches zero, alarm
    send_event(EV_STOP,  4'd15,   1'b0);   // already in set mode
    send_event(EV_CLEAR, 4'd15,   1'b1);
    drain_results();
  endtask

  // Preset at the edges: zero, day max, all ones (saturates), one past max.
  task automatic test_preset_extremes();
    logic [16:0] edge_vals[4] = '{17'd0, 17'd86399, 17'h1FFFF, 17'd86400};
    foreach (edge_vals[i]) begin
      write_preset(edge_vals[i]);
      send_event(EV_HOLD, 4'd0,    1'b1);
      send_event(EV_INC,  CUR_1S,  1'b1);  // refused at 23:59:59
      send_event(EV_INC,  CUR_10H, 1'b1);
      send_event(EV_DEC,  CUR_10H, 1'b1);
      send_event(EV_HOLD, 4'd0,    1'b0);  // off page, ignored
      drain_results();
    end
  endtask

  // Receiver holds off for a long stretch while input words keep coming,
  // so the pipe fills and s_tready must drop.
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_reqs++;
    repeat (40) send_noise();
    drain_results();
  endtask

  task automatic test_random_events(input int src_pct, input int sink_pct);
    int first;
    // mostly short presets so runs expire; sometimes the full 17-bit range
    write_preset(($urandom_range(3) == 0) ? 17'($urandom_range(17'h1FFFF))
                                          : 17'($urandom_range(90)));
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    first = items_sent;
    while (items_sent - first < RANDOM_PER_PHASE) begin
      if ($urandom_range(3) == 0) send_noise();
      else countdown_sequence();
    end
    drain_results();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_events();
    test_preset_extremes();
    test_output_backpressure();
    test_random_events(0, 0);
    test_random_events(70, 0);
    test_random_events(0, 70);
    test_random_events(21, 21);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ digit_settable_countdown_timer_unit.f @@
+incdir+hdl
hdl/dsct_pkg.sv
hdl/dsct_core.sv
hdl/dsct_hms.sv
hdl/digit_settable_countdown_timer_unit.sv
test/tb_top.sv
